// ===== rtl/tmstep_pkg.sv =====
// Shared types and constants for the Turing machine step unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmstep_pkg;

	// Field widths of the stream words
	localparam int SYM_W     = 8;
	localparam int ST_W      = 8;
	localparam int HEAD_W    = 10;
	localparam int RIDX_W    = 6;
	localparam int RCOUNT_W  = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 32;

	// Default sizes of the two stores
	localparam int RULE_SLOTS_DEF = 64;
	localparam int TAPE_CELLS_DEF = 1024;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RULE_COUNT = 1'b0,
		CFG_START_HEAD = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_LOAD_RULE  = 2'd0,
		OP_WRITE_CELL = 2'd1,
		OP_RESTART    = 2'd2,
		OP_STEP       = 2'd3
	} op_t;

	typedef struct packed {
		logic [ST_W-1:0]  state;
		logic [SYM_W-1:0] read_sym;
		logic [SYM_W-1:0] write_sym;
		logic             move_right;
		logic [ST_W-1:0]  next_state;
	} rule_t;

	// Input word, operation in the lowest bits
	typedef struct packed {
		logic [4:0]        pad;
		logic [SYM_W-1:0]  cell_symbol;
		logic [HEAD_W-1:0] cell_address;
		logic [ST_W-1:0]   rule_next_state;
		logic              rule_move_right;
		logic [SYM_W-1:0]  rule_write_symbol;
		logic [SYM_W-1:0]  rule_read_symbol;
		logic [ST_W-1:0]   rule_state;
		logic [RIDX_W-1:0] rule_index;
		op_t               operation;
	} in_word_t;

	// Result word, matched in the lowest bit
	typedef struct packed {
		logic [3:0]        pad;
		logic              head_fault;
		logic [SYM_W-1:0]  written_symbol;
		logic [HEAD_W-1:0] head_position;
		logic [ST_W-1:0]   current_state;
		logic              matched;
	} out_word_t;

endpackage

`default_nettype wire

// ===== rtl/turing_machine_step_unit.sv =====
// Top level of the single-tape Turing machine step unit: tape memory,
// control sequencer, configuration registers and result register.
// Depends on tmstep_pkg and tmstep_rules.
//
//  channel  | signals                        | width | role
//  ---------+--------------------------------+-------+----------------------------
//  s_axis   | s_tvalid s_tready s_tdata      | 64    | command word in
//  m_axis   | m_tvalid m_tready m_tdata      | 32    | result word out
//  cfg      | cfg_wen cfg_index cfg_wdata    | 1/10  | register write, no read-back
//
// Load rule, write cell and restart pass from accept through res_q into the
// output register. A step scans n = min(rule_count, RULE_SLOTS) rules, one per
// cycle from the single port of the rule memory, so the scan sets its length.
// A step stops early on the first matching rule.
// Reset clears state, head, registers and the result valid; both memories
// hold garbage until written. A stalled result holds in the output register
// while the next word is already accepted and worked on.
`default_nettype none

module turing_machine_step_unit import tmstep_pkg::*; #(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF,
	parameter int TAPE_CELLS = TAPE_CELLS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [1:0] operation, [7:2] rule_index, [15:8] rule_state,
	// [23:16] rule_read_symbol, [31:24] rule_write_symbol, [32] rule_move_right,
	// [40:33] rule_next_state, [50:41] cell_address, [58:51] cell_symbol
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [0] matched, [8:1] current_state, [18:9] head_position,
	// [26:19] written_symbol, [27] head_fault
	output logic [OUT_TDATA_W-1:0]     m_tdata,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int RIW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CW  = $clog2(RULE_SLOTS + 1);
	localparam int TW  = $clog2(TAPE_CELLS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} fsm_t;

	fsm_t                  state_q;
	logic [ST_W-1:0]       mstate_q;     // machine state
	logic [TW-1:0]         head_q;
	logic [RCOUNT_W-1:0]   rule_count_q;
	logic [HEAD_W-1:0]     start_head_q;
	logic [CW-1:0]         chk_q;        // rule index whose data sits in the read reg
	logic                  m_tvalid_q;
	out_word_t             res_q;
	out_word_t             m_word_q;

	in_word_t              in_w;
	logic                  s_acc;
	logic                  is_step;
	logic [CW-1:0]         chk_nxt;
	logic                  scan_end;
	logic                  scan_done;
	logic                  match;
	logic                  fault;
	logic [TW-1:0]         head_new;
	logic [TW-1:0]         head_sat;
	logic                  cell_ok;
	logic                  rule_ok;
	out_word_t             res_d;
	logic                  res_we;
	logic                  out_load;

	// tape memory
	logic [SYM_W-1:0]      tape_mem [TAPE_CELLS];
	logic [SYM_W-1:0]      tape_rd_q;
	logic                  tape_we;
	logic [TW-1:0]         tape_wa;
	logic [SYM_W-1:0]      tape_wd;
	logic                  tape_re;

	// rule memory port
	logic                  rule_we;
	rule_t                 rule_wr;
	logic                  rule_re;
	logic [RIW-1:0]        rule_ra;
	rule_t                 rule_rd;
	logic                  rule_hit;

	assign in_w     = in_word_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_step  = (in_w.operation == OP_STEP);

	// scan bookkeeping: chk_q at or past n means no rule left
	assign chk_nxt  = chk_q + 1'b1;
	assign scan_end = (32'(chk_q) >= 32'(rule_count_q)) || (32'(chk_q) >= RULE_SLOTS);
	assign match    = !scan_end && rule_hit;
	assign scan_done = (state_q == ST_SCAN) && (scan_end || rule_hit);

	// head move; hold and flag at either end of the tape
	always_comb begin
		head_new = head_q;
		fault    = 1'b0;
		if (rule_rd.move_right) begin
			if (32'(head_q) + 1 < TAPE_CELLS) begin
				head_new = head_q + 1'b1;
			end else begin
				fault = 1'b1;
			end
		end else begin
			if (head_q != '0) begin
				head_new = head_q - 1'b1;
			end else begin
				fault = 1'b1;
			end
		end
	end

	assign head_sat = (32'(start_head_q) < TAPE_CELLS) ? TW'(start_head_q) : TW'(TAPE_CELLS - 1);
	assign cell_ok  = (32'(in_w.cell_address) < TAPE_CELLS);
	assign rule_ok  = (32'(in_w.rule_index) < RULE_SLOTS);

	// rule memory control: index 0 on step accept, then one per scan cycle
	always_comb begin
		rule_we = s_acc && (in_w.operation == OP_LOAD_RULE) && rule_ok;
		rule_wr = '{state:      in_w.rule_state,
		            read_sym:   in_w.rule_read_symbol,
		            write_sym:  in_w.rule_write_symbol,
		            move_right: in_w.rule_move_right,
		            next_state: in_w.rule_next_state};
		rule_re = 1'b0;
		rule_ra = RIW'(chk_nxt);
		if (s_acc && is_step) begin
			rule_re = 1'b1;
			rule_ra = '0;
		end else if ((state_q == ST_SCAN) && !scan_done && (32'(chk_nxt) < RULE_SLOTS)) begin
			rule_re = 1'b1;
		end
	end

	tmstep_rules #(
		.RULE_SLOTS(RULE_SLOTS)
	) u_rules (
		.clk       (clk),
		.wr_en     (rule_we),
		.wr_idx    (RIW'(in_w.rule_index)),
		.wr_rule   (rule_wr),
		.rd_en     (rule_re),
		.rd_idx    (rule_ra),
		.key_state (mstate_q),
		.key_sym   (tape_rd_q),
		.rd_rule   (rule_rd),
		.hit       (rule_hit)
	);

	// tape: write on cell load or on a matched step, read under the head
	always_comb begin
		tape_re = s_acc && is_step;
		tape_we = 1'b0;
		tape_wa = TW'(in_w.cell_address);
		tape_wd = in_w.cell_symbol;
		if (s_acc && (in_w.operation == OP_WRITE_CELL) && cell_ok) begin
			tape_we = 1'b1;
		end else if (scan_done && match) begin
			tape_we = 1'b1;
			tape_wa = head_q;
			tape_wd = rule_rd.write_sym;
		end
	end

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_wa] <= tape_wd;
		end
		if (tape_re) begin
			tape_rd_q <= tape_mem[head_q];
		end
	end

	// result of the item being finished
	always_comb begin
		res_d                = '0;
		res_d.current_state  = mstate_q;
		res_d.head_position  = HEAD_W'(head_q);
		res_we               = 1'b0;
		if (s_acc) begin
			res_we = !is_step;
			unique case (in_w.operation)
				OP_LOAD_RULE: ;
				OP_WRITE_CELL: begin
					res_d.written_symbol = cell_ok ? in_w.cell_symbol : '0;
				end
				OP_RESTART: begin
					res_d.current_state = '0;
					res_d.head_position = HEAD_W'(head_sat);
				end
				OP_STEP: ;
			endcase
		end else if (scan_done) begin
			res_we               = 1'b1;
			res_d.matched        = match;
			res_d.written_symbol = match ? rule_rd.write_sym : tape_rd_q;
			res_d.head_fault     = match && fault;
			if (match) begin
				res_d.current_state = rule_rd.next_state;
				if (!fault) begin
					res_d.head_position = HEAD_W'(head_new);
				end
			end
		end
	end

	assign out_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_q <= res_d;
		end
		if (out_load) begin
			m_word_q <= res_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mstate_q     <= '0;
			head_q       <= '0;
			rule_count_q <= '0;
			start_head_q <= '0;
			chk_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_RULE_COUNT: rule_count_q <= cfg_wdata[RCOUNT_W-1:0];
					CFG_START_HEAD: start_head_q <= cfg_wdata;
				endcase
			end

			// a new word replaces the one taken in the same cycle
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (is_step) begin
							chk_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_EMIT;
						end
						if (in_w.operation == OP_RESTART) begin
							mstate_q <= '0;
							head_q   <= head_sat;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (match) begin
							mstate_q <= rule_rd.next_state;
							if (!fault) begin
								head_q <= head_new;
							end
						end
						state_q <= ST_EMIT;
					end else begin
						chk_q <= chk_nxt;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(m_word_q);

endmodule

`default_nettype wire

// ===== rtl/tmstep_rules.sv =====
// Rule table memory with registered read and first-stage match compare.
// Depends on tmstep_pkg.
`default_nettype none

module tmstep_rules import tmstep_pkg::*; #(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF,
	localparam int RIW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [RIW-1:0]   wr_idx,
	input  wire rule_t            wr_rule,
	input  wire logic             rd_en,
	input  wire logic [RIW-1:0]   rd_idx,
	input  wire logic [ST_W-1:0]  key_state,
	input  wire logic [SYM_W-1:0] key_sym,
	output rule_t                 rd_rule,
	output logic                  hit
);

	rule_t rule_mem [RULE_SLOTS];
	rule_t rd_rule_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_mem[wr_idx] <= wr_rule;
		end
		if (rd_en) begin
			rd_rule_q <= rule_mem[rd_idx];
		end
	end

	assign rd_rule = rd_rule_q;
	assign hit     = (rd_rule_q.state == key_state) && (rd_rule_q.read_sym == key_sym);

endmodule

`default_nettype wire

// ===== rtl/tmstep_checker.sv =====
// Port-level checks for the Turing machine step unit, bound to the top level.
// Depends on tmstep_pkg and turing_machine_step_unit.
`default_nettype none

module tmstep_checker import tmstep_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready
);

	out_word_t m_w;
	assign m_w = out_word_t'(m_tdata);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

	// a head fault only comes with an applied rule
	a_fault_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_w.head_fault |-> m_w.matched)
		else $error("head fault without a matched rule");

	// a result word never shows up right after one was taken with no new input
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && s_tready |=> !m_tvalid)
		else $error("result word appeared without an input");

endmodule

bind turing_machine_step_unit tmstep_checker u_tmstep_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire

// ===== sim/turing_machine_step_unit_tb.sv =====
// Testbench for turing_machine_step_unit: a directed table followed by random machine programs.
// Each result is checked against a typed row or a mirror of rule table, tape, state and head.
// Depends on tmstep_pkg and the RTL of the step unit; reads no files.
`timescale 1ns / 100ps

module turing_machine_step_unit_tb;
	import tmstep_pkg::*;

	localparam int CYCLE_LIMIT  = 800_000;
	localparam int ITEM_TARGET  = 1450;
	localparam int CFG_SETTLE   = 4;    // every word gives a result, so a short pause is enough
	localparam int END_SETTLE   = 100;  // longer than a full 64-rule scan
	localparam int MAX_REPORTS  = 40;

	typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

	// One row of the directed plan. A register row uses reg_sel/reg_val only.
	// With typed set, the x_* columns are the expected result word.
	typedef struct {
		row_kind_t   kind;
		cfg_idx_t    reg_sel;
		int unsigned reg_val;
		op_t         op;
		int unsigned rule_idx, st, rd, wr, mv, nx, addr, sym;
		bit          typed;
		int unsigned x_hit, x_state, x_head, x_sym, x_fault;
	} plan_row_t;

	// Directed plan, starting right after reset (state 0, head 0, rule_count 0).
	plan_row_t plan [24] = '{
		// rule_count 0: a step only reads the cell under the head
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_WRITE_CELL, 0, 0, 0, 0, 0, 0, 'h000, 'hFF,
			1, 0, 'h00, 'h000, 'hFF, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 'h00, 'h000, 'hFF, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_WRITE_CELL, 0, 0, 0, 0, 0, 0, 'h3FF, 'h00,
			1, 0, 'h00, 'h000, 'h00, 0},
		// field extremes in the first two rules
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_LOAD_RULE, 0, 'h00, 'hFF, 'h00, 0, 'hFF, 0, 0,
			1, 0, 'h00, 'h000, 'h00, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_LOAD_RULE, 1, 'hFF, 'h00, 'hFF, 1, 'h00, 0, 0,
			1, 0, 'h00, 'h000, 'h00, 0},
		'{ROW_CFG, CFG_RULE_COUNT, 2, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0},
		// left move off cell 0: head holds, write and state change still happen
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 1, 'hFF, 'h000, 'h00, 1},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 1, 'h00, 'h001, 'hFF, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_WRITE_CELL, 0, 0, 0, 0, 0, 0, 'h001, 'h5A,
			1, 0, 'h00, 'h001, 'h5A, 0},
		// no rule fits: symbol under the head comes back, nothing moves
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 'h00, 'h001, 'h5A, 0},
		'{ROW_CFG, CFG_START_HEAD, 'h3FF, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 'h00, 'h3FF, 'h00, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_LOAD_RULE, 1, 'h00, 'h00, 'hC3, 1, 'h80, 0, 0,
			1, 0, 'h00, 'h3FF, 'h00, 0},
		// right move off the last cell
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 1, 'h80, 'h3FF, 'hC3, 1},
		'{ROW_CFG, CFG_RULE_COUNT, 1, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 'h80, 'h3FF, 'hC3, 0},
		'{ROW_CFG, CFG_START_HEAD, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 'h00, 'h000, 'h00, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 1, 'hFF, 'h000, 'h00, 1},
		// alternating bit patterns, checked by the mirror
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_WRITE_CELL, 0, 0, 0, 0, 0, 0, 'h2AA, 'h96,
			0, 0, 0, 0, 0, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_WRITE_CELL, 0, 0, 0, 0, 0, 0, 'h155, 'h69,
			0, 0, 0, 0, 0, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_LOAD_RULE, 'h2A, 'hAA, 'h55, 'h96, 1, 'h69, 0, 0,
			0, 0, 0, 0, 0, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0},
		'{ROW_WORD, CFG_RULE_COUNT, 0, OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_wen;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Mirror of the machine, updated when a word is accepted
	rule_t             rule_mirror [RULE_SLOTS_DEF];
	logic [SYM_W-1:0]  tape_mirror [TAPE_CELLS_DEF];
	bit                rule_loaded [RULE_SLOTS_DEF];
	bit                cell_loaded [TAPE_CELLS_DEF];
	logic [ST_W-1:0]   mach_state;
	logic [HEAD_W-1:0] mach_head;
	logic [RCOUNT_W-1:0] rule_count_q;
	logic [HEAD_W-1:0] start_head_q;

	out_word_t   pending_results [$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned words_sent = 0;
	int unsigned cycles = 0;
	bit          tx_burst;
	bit          rx_burst;

	turing_machine_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one word to the mirror and return the result word it must produce
	function automatic out_word_t advance_machine(input in_word_t w);
		out_word_t         r;
		int                n;
		int                k;
		int                sel;
		logic [HEAD_W-1:0] pos;
		r = '0;
		sel = -1;
		case (w.operation)
			OP_LOAD_RULE: begin
				rule_mirror[w.rule_index] = '{state: w.rule_state,
					read_sym: w.rule_read_symbol, write_sym: w.rule_write_symbol,
					move_right: w.rule_move_right, next_state: w.rule_next_state};
				rule_loaded[w.rule_index] = 1'b1;
			end
			OP_WRITE_CELL: begin
				tape_mirror[w.cell_address] = w.cell_symbol;
				cell_loaded[w.cell_address] = 1'b1;
				r.written_symbol = w.cell_symbol;
			end
			OP_RESTART: begin
				mach_state = '0;
				mach_head = start_head_q;
			end
			OP_STEP: begin
				// counts above the table size scan the whole table
				n = (rule_count_q > RULE_SLOTS_DEF) ? RULE_SLOTS_DEF : rule_count_q;
				pos = mach_head;
				for (k = 0; k < n; k++)
					if (sel < 0 && rule_mirror[k].state == mach_state &&
							rule_mirror[k].read_sym == tape_mirror[pos])
						sel = k;
				if (sel >= 0) begin
					tape_mirror[pos] = rule_mirror[sel].write_sym;
					mach_state = rule_mirror[sel].next_state;
					r.matched = 1'b1;
					if (rule_mirror[sel].move_right) begin
						if (pos == TAPE_CELLS_DEF - 1)
							r.head_fault = 1'b1;
						else
							pos++;
					end else begin
						if (pos == 0)
							r.head_fault = 1'b1;
						else
							pos--;
					end
					mach_head = pos;
				end
				r.written_symbol = tape_mirror[mach_head == pos && sel < 0 ? pos : 
					(r.head_fault ? pos : (rule_mirror[sel].move_right ? pos - 1 : pos + 1))];
			end
		endcase
		r.current_state = mach_state;
		r.head_position = mach_head;
		return r;
	endfunction

	// Random word with a small alphabet so rules keep firing. A step that would read
	// a cell or an in-use rule never written since reset becomes the write that fixes it.
	function automatic in_word_t random_word();
		in_word_t    w;
		int unsigned pick;
		int          n;
		int          k;
		int          hole;
		w = {$urandom, $urandom};
		w.pad = '0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			w.operation = OP_STEP;
		else if (pick < 72)
			w.operation = OP_WRITE_CELL;
		else if (pick < 90)
			w.operation = OP_LOAD_RULE;
		else
			w.operation = OP_RESTART;
		if ($urandom_range(0, 7) != 0) begin
			w.rule_state        = ST_W'($urandom_range(0, 3));
			w.rule_read_symbol  = SYM_W'($urandom_range(0, 3));
			w.rule_write_symbol = SYM_W'($urandom_range(0, 3));
			w.rule_next_state   = ST_W'($urandom_range(0, 3));
			w.cell_symbol       = SYM_W'($urandom_range(0, 3));
		end
		if (w.operation == OP_WRITE_CELL && $urandom_range(0, 3) != 0)
			w.cell_address = mach_head + HEAD_W'($urandom_range(0, 4)) - HEAD_W'(2);
		if (w.operation == OP_STEP) begin
			n = (rule_count_q > RULE_SLOTS_DEF) ? RULE_SLOTS_DEF : rule_count_q;
			hole = -1;
			for (k = n - 1; k >= 0; k--)
				if (!rule_loaded[k])
					hole = k;
			if (!cell_loaded[mach_head]) begin
				w.operation = OP_WRITE_CELL;
				w.cell_address = mach_head;
			end else if (hole >= 0) begin
				w.operation = OP_LOAD_RULE;
				w.rule_index = RIDX_W'(hole);
			end
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $time, results_seen,
				what, got, want);
		mismatches++;
	endtask

	// Offer one word after a random gap (none in a burst); the mirror advances when it is taken
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_want);
		int unsigned gap;
		out_word_t   predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = advance_machine(w);
		pending_results.push_back(typed ? typed_want : predicted);
		words_sent++;
	endtask

	// Stop offering words and wait until every result is back
	task automatic wait_idle(input int unsigned settle);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (sel == CFG_RULE_COUNT)
			rule_count_q = value[RCOUNT_W-1:0];
		else
			start_head_q = value;
	endtask

	// Result sink: unless in a burst, ready drops for a random stall, counted while a word waits
	initial begin : result_sink
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 6);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				while (stall > 0) begin
					@(posedge clk);
					if (m_tvalid)
						stall--;
				end
				@(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Result checker, oldest expectation first
	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing pending", got, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.matched !== want.matched)
					report_mismatch("matched", got.matched, want.matched);
				if (got.current_state !== want.current_state)
					report_mismatch("current_state", got.current_state, want.current_state);
				if (got.head_position !== want.head_position)
					report_mismatch("head_position", got.head_position, want.head_position);
				if (got.written_symbol !== want.written_symbol)
					report_mismatch("written_symbol", got.written_symbol, want.written_symbol);
				if (got.head_fault !== want.head_fault)
					report_mismatch("head_fault", got.head_fault, want.head_fault);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		in_word_t    w;
		out_word_t   want;
		int unsigned prog_len;
		int unsigned body_len;
		int unsigned count_val;
		int unsigned head_val;
		int unsigned phase;
		int unsigned j;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_wen   = 1'b0;
		cfg_index = CFG_RULE_COUNT;
		cfg_wdata = '0;
		tx_burst  = 1'b0;
		rx_burst  = 1'b0;
		mach_state = '0;
		mach_head = '0;
		rule_count_q = '0;
		start_head_q = '0;
		foreach (rule_loaded[i])
			rule_loaded[i] = 1'b0;
		foreach (cell_loaded[i])
			cell_loaded[i] = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_idle(CFG_SETTLE);
				write_register(plan[i].reg_sel, CFG_DATA_W'(plan[i].reg_val));
			end else begin
				w = '0;
				w.operation         = plan[i].op;
				w.rule_index        = RIDX_W'(plan[i].rule_idx);
				w.rule_state        = ST_W'(plan[i].st);
				w.rule_read_symbol  = SYM_W'(plan[i].rd);
				w.rule_write_symbol = SYM_W'(plan[i].wr);
				w.rule_move_right   = plan[i].mv[0];
				w.rule_next_state   = ST_W'(plan[i].nx);
				w.cell_address      = HEAD_W'(plan[i].addr);
				w.cell_symbol       = SYM_W'(plan[i].sym);
				want = '0;
				want.matched        = plan[i].x_hit[0];
				want.current_state  = ST_W'(plan[i].x_state);
				want.head_position  = HEAD_W'(plan[i].x_head);
				want.written_symbol = SYM_W'(plan[i].x_sym);
				want.head_fault     = plan[i].x_fault[0];
				send_word(w, plan[i].typed, want);
			end
		end

		// Random phases: load a short program, set the registers while idle, restart,
		// then run a mix that is mostly steps. The first phase, and now and then a later one, loads the whole table.
		phase = 0;
		while (words_sent < ITEM_TARGET) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			prog_len = (phase == 0 || $urandom_range(0, 7) == 0) ? RULE_SLOTS_DEF :
				$urandom_range(1, 12);
			for (j = 0; j < prog_len; j++) begin
				w = random_word();
				w.operation         = OP_LOAD_RULE;
				w.rule_index        = RIDX_W'(j);
				w.rule_state        = ST_W'($urandom_range(0, 3));
				w.rule_read_symbol  = SYM_W'($urandom_range(0, 3));
				w.rule_next_state   = ST_W'($urandom_range(0, 3));
				send_word(w, 1'b0, '0);
			end
			wait_idle(CFG_SETTLE);
			if (phase == 0)
				count_val = 127;
			else if (phase == 1)
				count_val = RULE_SLOTS_DEF;
			else
				case ($urandom_range(0, 5))
					0, 1, 2: count_val = prog_len;
					3:       count_val = 0;
					4:       count_val = RULE_SLOTS_DEF;
					default: count_val = $urandom_range(RULE_SLOTS_DEF + 1, 127);
				endcase
			case ($urandom_range(0, 4))
				0:       head_val = 0;
				1:       head_val = TAPE_CELLS_DEF - 1;
				2:       head_val = $urandom_range(0, 3);
				3:       head_val = $urandom_range(TAPE_CELLS_DEF - 4, TAPE_CELLS_DEF - 1);
				default: head_val = $urandom_range(0, TAPE_CELLS_DEF - 1);
			endcase
			write_register(CFG_RULE_COUNT, CFG_DATA_W'(count_val));
			write_register(CFG_START_HEAD, CFG_DATA_W'(head_val));
			w = random_word();
			w.operation = OP_RESTART;
			send_word(w, 1'b0, '0);
			body_len = $urandom_range(50, 110);
			for (j = 0; j < body_len && words_sent < ITEM_TARGET; j++) begin
				// now and then let the pipeline run dry before the next word
				if ($urandom_range(0, 59) == 0)
					wait_idle(0);
				send_word(random_word(), 1'b0, '0);
			end
			phase++;
		end

		wait_idle(END_SETTLE);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
